// File: rtl/core/mfdl_pkg.sv
package mfdl_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_BLOCK   = 4096;

    localparam int GAIN_BITS   = 16;
    localparam int TARGET_BITS = 31;
    localparam int LEN_BITS    = 13;
    localparam int POS_BITS    = 32;
    localparam int FRAC_BITS   = 15;

    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int FB_BITS     = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 3;

    localparam int DIV_STEPS   = POS_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = GAIN_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLIDE_ENABLE  = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_load;
        logic advance;
        logic multiply;
        logic commit;
    } mfdl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } mfdl_status_t;

endpackage

// File: rtl/core/mfdl_ram.sv
module mfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mfdl_div.sv
module mfdl_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [mfdl_pkg::POS_BITS-1:0] dividend,
    input  logic [mfdl_pkg::LEN_BITS-1:0]   divisor,
    output logic                            done,
    output logic [mfdl_pkg::POS_BITS-1:0]   quotient
);

    import mfdl_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [LEN_BITS-1:0]  rem_reg;
    logic [LEN_BITS-1:0]  div_reg;
    logic [POS_BITS-1:0]  quo_reg;
    logic                 neg_reg;

    logic [POS_BITS-1:0]  magnitude;
    logic [LEN_BITS:0]    shifted;
    logic                 fits;
    logic [LEN_BITS:0]    rem_diff;
    logic [LEN_BITS-1:0]  rem_next;
    logic [POS_BITS-1:0]  quo_next;

    assign magnitude = dividend[POS_BITS-1] ? (~dividend + 1'b1) : dividend;

    // one quotient bit per cycle, restoring form
    assign shifted  = {rem_reg, quo_reg[POS_BITS-1]};
    assign fits     = shifted >= {1'b0, div_reg};
    assign rem_diff = shifted - {1'b0, div_reg};
    assign rem_next = fits ? rem_diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
    assign quo_next = {quo_reg[POS_BITS-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude;
            div_reg <= divisor;
            neg_reg <= dividend[POS_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// File: rtl/core/mfdl_datapath.sv
module mfdl_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mfdl_pkg::mfdl_cmd_t                    cmd,
    output mfdl_pkg::mfdl_status_t                 status,
    input  logic signed [mfdl_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   block_start,
    input  logic [mfdl_pkg::TARGET_BITS-1:0]       target_delay,
    input  logic [mfdl_pkg::LEN_BITS-1:0]          block_length,
    input  logic                                   cfg_valid,
    input  logic [mfdl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mfdl_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic signed [mfdl_pkg::SAMPLE_BITS-1:0] delayed_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready
);

    import mfdl_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration and control state
    logic [GAIN_BITS-1:0]   gain_reg;
    logic                   glide_reg;
    logic [ADDR_BITS-1:0]   widx_reg;
    logic                   wrapped_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    step_reg;
    logic [TARGET_BITS-1:0] last_reg;
    logic                   out_valid_reg;

    // per-item payload
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [TARGET_BITS-1:0]        target_reg;
    logic                          direct_reg;
    logic                          tap_valid_reg;
    logic signed [SAMPLE_BITS-1:0] tapped_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    logic signed [POS_BITS-1:0]    diff;
    logic [LEN_BITS-1:0]           len_clamped;
    logic                          div_done;
    logic [POS_BITS-1:0]           div_quotient;
    logic                          set_target;
    logic [POS_BITS-1:0]           pos_next;
    logic [ADDR_BITS-1:0]          offset;
    logic [ADDR_BITS-1:0]          tap_addr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] tapped;
    logic signed [PROD_BITS-1:0]   prod_shift;
    logic                          round_up;
    logic signed [FB_BITS-1:0]     feedback;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SAMPLE_BITS-1:0] sat_value;

    // signed ramp distance; always fits in the position width
    assign diff = $signed({1'b0, target_delay}) - $signed({1'b0, last_reg});

    always_comb
    begin
        if (block_length == '0)
        begin
            len_clamped = LEN_BITS'(1);
        end
        else if (block_length > LEN_BITS'(MAX_BLOCK))
        begin
            len_clamped = LEN_BITS'(MAX_BLOCK);
        end
        else
        begin
            len_clamped = block_length;
        end
    end

    mfdl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff),
        .divisor  (len_clamped),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign set_target = cmd.accept & block_start & ~glide_reg;
    assign pos_next   = set_target ? POS_BITS'(target_delay) : pos_reg + step_reg;
    assign offset     = pos_next[FRAC_BITS +: ADDR_BITS];
    assign tap_addr   = widx_reg - offset;

    assign tapped = tap_valid_reg ? $signed(ram_rdata) : '0;

    // truncate toward zero: bump the floored quotient when negative and inexact
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign round_up   = prod_reg[PROD_BITS-1] & (prod_reg[FRAC_BITS-1:0] != '0);
    assign feedback   = FB_BITS'(prod_shift) + FB_BITS'(round_up);
    assign sum        = SUM_BITS'(sample_reg) + SUM_BITS'(feedback);

    always_comb
    begin
        if (sum > SUM_BITS'(SAT_HI))
        begin
            sat_value = SAT_HI;
        end
        else if (sum < SUM_BITS'(SAT_LO))
        begin
            sat_value = SAT_LO;
        end
        else
        begin
            sat_value = sum[SAMPLE_BITS-1:0];
        end
    end

    mfdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (widx_reg),
        .wdata (sat_value),
        .re    (cmd.advance),
        .raddr (tap_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= '0;
            glide_reg     <= 1'b0;
            widx_reg      <= '0;
            wrapped_reg   <= 1'b0;
            pos_reg       <= '0;
            step_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FEEDBACK_GAIN: gain_reg  <= cfg_data;
                    REG_GLIDE_ENABLE:  glide_reg <= cfg_data[0];
                    default:           gain_reg  <= gain_reg;
                endcase
            end

            if (set_target)
            begin
                step_reg <= '0;
                last_reg <= target_delay;
            end
            if (cmd.div_load)
            begin
                pos_reg  <= POS_BITS'(last_reg);
                step_reg <= div_quotient;
                last_reg <= target_reg;
            end
            if (cmd.advance)
            begin
                pos_reg <= pos_next;
            end

            if (cmd.commit)
            begin
                widx_reg <= widx_reg + 1'b1;
                if (widx_reg == {ADDR_BITS{1'b1}})
                begin
                    wrapped_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
            target_reg <= target_delay;
        end
        if (cmd.advance)
        begin
            direct_reg    <= (offset == '0);
            tap_valid_reg <= wrapped_reg | (tap_addr < widx_reg);
        end
        if (cmd.multiply)
        begin
            tapped_reg <= tapped;
            prod_reg   <= PROD_BITS'(tapped) * $signed({1'b0, gain_reg});
        end
        if (cmd.commit)
        begin
            out_data_reg <= direct_reg ? sat_value : tapped_reg;
        end
    end

    assign status.need_div = block_start & glide_reg;
    assign status.div_done = div_done;
    assign status.out_free = ~out_valid_reg | out_ready;

    assign delayed_sample = out_data_reg;
    assign out_valid      = out_valid_reg;

endmodule

// File: rtl/core/mfdl_ctrl.sv
module mfdl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mfdl_pkg::mfdl_status_t status,
    output mfdl_pkg::mfdl_cmd_t    cmd
);

    import mfdl_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_WR   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    if (status.need_div)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                // hold until the output slot frees up
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/modulated_feedback_delay_line.sv
// Sequence: an accepted item reads the store tap, then is multiplied by the gain, then is written
// back and loads the output register, waiting in the write state while the output slot is full; a
// block-start item with glide on first runs the 32-step ramp divider. A new item is taken only once
// the last one has been written back.
// Reset: asynchronous, active low; clears the control state, gain and glide; the delay store
// reads as zero until each entry is first written, so no clearing pass is needed.
module modulated_feedback_delay_line (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input item channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mfdl_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   block_start,
    input  logic [mfdl_pkg::TARGET_BITS-1:0]       target_delay,
    input  logic [mfdl_pkg::LEN_BITS-1:0]          block_length,
    // result item channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mfdl_pkg::SAMPLE_BITS-1:0] delayed_sample,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mfdl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mfdl_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import mfdl_pkg::*;

    mfdl_cmd_t    cmd;
    mfdl_status_t status;

    // Register writes are always taken, so the port never stalls.
    assign cfg_ready = 1'b1;

    // Sequencer: accept an item, optionally run the ramp divider on a glide
    // block start, advance the ramp and read the tap, multiply by the gain,
    // then write back and load the output register.
    mfdl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: ramp position and step, write index with fill tracking,
    // delay store, feedback multiply, saturation and output register.
    mfdl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .block_start    (block_start),
        .target_delay   (target_delay),
        .block_length   (block_length),
        .cfg_valid      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .delayed_sample (delayed_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

// File: rtl/core/mfdl_checker.sv
module mfdl_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [mfdl_pkg::SAMPLE_BITS-1:0] delayed_sample,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(delayed_sample))
        else $error("stalled result dropped or changed");

    // one item at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    // a result cannot appear in the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // register writes never stall
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind modulated_feedback_delay_line mfdl_checker u_mfdl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .delayed_sample (delayed_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
);
